// ===== rtl/trh_pkg.sv =====
// Package for the Toeplitz receive-side-scaling hash unit.
// Holds word widths, register codes and the key window fold function.
// No dependencies.
package trh_pkg;

	localparam int KEY_BYTES_DEF = 40;
	localparam int CFG_REGS = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int DATA_W = 8;
	localparam int HASH_W = 32;
	localparam int WIN_BYTES = 5;
	localparam int WIN_W = WIN_BYTES * 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_WORD_0 = 3'd0,
		REG_KEY_WORD_1 = 3'd1,
		REG_KEY_WORD_2 = 3'd2,
		REG_KEY_WORD_3 = 3'd3,
		REG_KEY_WORD_4 = 3'd4
	} cfg_reg_t;

	// Each set input bit selects a 32-bit slice of the 40-bit key window,
	// moving down one bit for each lower bit of the byte.
	function automatic logic [HASH_W-1:0] fold_window(input logic [WIN_W-1:0] win,
			input logic [DATA_W-1:0] data);
		logic [HASH_W-1:0] acc;
		acc = '0;
		for (int b = 0; b < DATA_W; b++) begin
			if (data[DATA_W-1-b]) begin
				acc = acc ^ win[WIN_W-1-b -: HASH_W];
			end
		end
		return acc;
	endfunction

endpackage

// ===== rtl/trh_ifs.sv =====
// Channel interfaces of the Toeplitz hash unit: input bytes, hash results
// and key register writes. Depends on trh_pkg.
interface trh_in_if;
	import trh_pkg::*;
	logic valid;
	logic ready;
	logic [DATA_W-1:0] data_byte;
	logic last_byte;
	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface trh_out_if;
	import trh_pkg::*;
	logic valid;
	logic ready;
	logic [HASH_W-1:0] hash_value;
	modport source (output valid, output hash_value, input ready);
	modport sink (input valid, input hash_value, output ready);
endinterface

interface trh_cfg_if;
	import trh_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/trh_key_regs.sv =====
// Key register file of the Toeplitz hash unit, stored as key bytes.
// Depends on trh_pkg and trh_cfg_if.
module trh_key_regs #(
	parameter int KEY_BYTES = trh_pkg::KEY_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	trh_cfg_if.sink cfg,
	output logic [KEY_BYTES-1:0][trh_pkg::DATA_W-1:0] key_bytes
);
	import trh_pkg::*;

	logic [KEY_BYTES-1:0][DATA_W-1:0] key_q;

	assign cfg.ready = 1'b1;
	assign key_bytes = key_q;

	for (genvar k = 0; k < KEY_BYTES; k++) begin : g_key
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				key_q[k] <= '0;
			end else if (cfg.valid && cfg.index == cfg_reg_t'(k / 8)) begin
				key_q[k] <= cfg.data[CFG_DATA_W-1-8*(k%8) -: DATA_W];
			end
		end
	end

endmodule

// ===== rtl/trh_hash_core.sv =====
// Input register, hash accumulator and result register of the Toeplitz
// hash unit. Depends on trh_pkg, trh_in_if and trh_out_if.
module trh_hash_core #(
	parameter int KEY_BYTES = trh_pkg::KEY_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic [KEY_BYTES-1:0][trh_pkg::DATA_W-1:0] key_bytes,
	trh_in_if.sink ingress,
	trh_out_if.source egress
);
	import trh_pkg::*;

	localparam int PW = $clog2(KEY_BYTES - 3);
	localparam int IW = $clog2(KEY_BYTES);
	localparam logic [PW-1:0] POS_LIMIT = PW'(KEY_BYTES - 4);

	logic valid_s1;
	logic [DATA_W-1:0] data_s1;
	logic last_s1;
	logic [HASH_W-1:0] accum_q;
	logic [PW-1:0] pos_q;
	logic out_valid_q;
	logic [HASH_W-1:0] out_hash_q;

	logic advance;
	logic take;
	logic [PW-1:0] pos_eff;
	logic [WIN_W-1:0] win;
	logic [HASH_W-1:0] accum_next;

	assign advance = valid_s1 && (!last_s1 || !out_valid_q || egress.ready);
	assign ingress.ready = !valid_s1 || advance;
	assign take = pos_q < POS_LIMIT;
	assign pos_eff = take ? pos_q : '0;

	for (genvar i = 0; i < WIN_BYTES; i++) begin : g_win
		logic [IW-1:0] idx;
		assign idx = IW'(pos_eff) + IW'(i);
		assign win[WIN_W-1-8*i -: DATA_W] = key_bytes[idx];
	end

	assign accum_next = take ? (accum_q ^ fold_window(win, data_s1)) : accum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ingress.ready) begin
			valid_s1 <= ingress.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ingress.ready && ingress.valid) begin
			data_s1 <= ingress.data_byte;
			last_s1 <= ingress.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			pos_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				accum_q <= '0;
				pos_q <= '0;
			end else begin
				accum_q <= accum_next;
				pos_q <= take ? pos_q + 1'b1 : pos_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (egress.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_hash_q <= accum_next;
		end
	end

	assign egress.valid = out_valid_q;
	assign egress.hash_value = out_hash_q;

endmodule

// ===== rtl/toeplitz_rss_hash_unit.sv =====
// Toeplitz receive-side-scaling hash unit: one input byte per word, hash out
// on the word marked last. A byte is held in the input register, then folded into
// the accumulator while its key window fits the key; a hash is valid on egress from
// the result register. One byte is accepted every cycle unless a last byte waits on a
// full result register. Reset clears the key, accumulator, position and valids.
// Depends on trh_pkg, the channel interfaces, trh_key_regs and trh_hash_core.
module toeplitz_rss_hash_unit #(
	parameter int KEY_BYTES = trh_pkg::KEY_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	trh_in_if.sink ingress,
	trh_out_if.source egress,
	trh_cfg_if.sink cfg
);
	import trh_pkg::*;

	logic [KEY_BYTES-1:0][DATA_W-1:0] key_bytes;

	trh_key_regs #(
		.KEY_BYTES(KEY_BYTES)
	) u_key_regs (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.key_bytes(key_bytes)
	);

	trh_hash_core #(
		.KEY_BYTES(KEY_BYTES)
	) u_hash_core (
		.clk(clk),
		.arst_n(arst_n),
		.key_bytes(key_bytes),
		.ingress(ingress),
		.egress(egress)
	);

endmodule
